/* sv/pba_pkg.sv */
// ============================================================================
// pba_pkg - shared types and constants of the page bitmap allocator
// Action and status codes, busy-map word geometry and counter limits.
// ============================================================================
package pba_pkg;

  // Busy-map memory word: 64 pages per word
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;

  // Page index and counter widths
  localparam int PAGE_W = 12;
  localparam int CNT_W  = 13;
  localparam logic [CNT_W-1:0] CNT_MAX = 13'd8191;

  // Register file: one register, word index taken from paddr[2]
  localparam logic REG_TRACKED_PAGES = 1'b0;
  localparam logic [CNT_W-1:0] TRACKED_RESET = 13'd4096;

  typedef enum logic [2:0] {
    ACT_LOCK      = 3'd0,
    ACT_FREE      = 3'd1,
    ACT_REQUEST   = 3'd2,
    ACT_RESERVE   = 3'd3,
    ACT_UNRESERVE = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_ALREADY = 2'd1,
    ST_NO_FREE = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

endpackage

/* sv/pba_map.sv */
// ============================================================================
// pba_map - busy-map storage
// Single-port-read, single-port-write synchronous memory of 64-bit words,
// registered read data.
// ============================================================================
module pba_map #(
  parameter int NW = 64,
  parameter int WA = 6
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [WA-1:0]                  rd_addr,
  output logic [pba_pkg::WORD_BITS-1:0]  rd_data,
  input  logic                           wr_en,
  input  logic [WA-1:0]                  wr_addr,
  input  logic [pba_pkg::WORD_BITS-1:0]  wr_data
);

  logic [pba_pkg::WORD_BITS-1:0] mem [NW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/page_bitmap_allocator_unit.sv */
// ============================================================================
// page_bitmap_allocator_unit - next-fit page frame allocator
// Busy bitmap in a 64-bit-wide memory, next-fit search, used/reserved counts.
// ============================================================================
// A request is taken at a clock edge where start is high and busy is low; its
// single result appears on the result ports for one cycle with done high and
// cannot be held off. After reset the block sweeps the busy map to zero, one
// 64-page word per cycle, and keeps busy high meanwhile; configuration writes
// are taken during the sweep. Unknown actions, out-of-range pages and an
// allocation request with no page tracked finish in the accepting cycle: done
// is registered, rises in the next cycle, and busy never rises. Lock, free,
// reserve and unreserve read one map word in the accepting cycle, then check it
// and write it back in the check state, which registers done.
// Any other allocation request walks the map through the single read port, one
// word per cycle but for a pause at the wrap, first from the search position to
// the last tracked page, then from page zero up to the search position: up to
// MAX_PAGES/64 + 1 word reads. busy drops in the cycle that done is high, so a
// new request can be taken then. tracked_pages sits at byte address 0 of the APB
// port; writes should land only while the block is idle.
// ============================================================================
module page_bitmap_allocator_unit #(
  parameter int MAX_PAGES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [11:0] page,
  // result channel
  output logic        done,
  output logic [11:0] granted_page,
  output logic [1:0]  status,
  output logic [12:0] used_pages,
  output logic [12:0] reserved_pages,
  output logic [12:0] free_pages,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int WB  = pba_pkg::WORD_BITS;
  localparam int BW  = pba_pkg::BIT_W;
  localparam int NW  = (MAX_PAGES + WB - 1) / WB;
  localparam int WA  = (NW > 1) ? $clog2(NW) : 1;
  localparam int XW  = ($clog2(MAX_PAGES) + 1 > 13) ? $clog2(MAX_PAGES) + 1 : 13;
  localparam int QW  = XW - BW;
  localparam int FW  = XW + 1;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_PAGES);
  localparam logic [WA-1:0] LAST_ADDR = WA'(NW - 1);
  localparam logic [WB-1:0] ONES = {WB{1'b1}};

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_CHECK} state_t;

  state_t      state;
  logic [WA-1:0] clr_addr;
  logic [2:0]  cur_action;
  logic [11:0] cur_page;
  logic [11:0] search_position;
  logic [12:0] used_count;
  logic [12:0] reserved_count;
  logic [12:0] tracked_pages;
  logic [XW-1:0] base;
  logic [XW-1:0] lim;
  logic        phase_one;
  logic [QW-1:0] scan_word;
  logic [QW-1:0] chk_word;
  logic        chk_valid;

  // memory ports
  logic          mem_rd_en;
  logic [WA-1:0] mem_rd_addr;
  logic [WB-1:0] mem_rd_data;
  logic          mem_wr_en;
  logic [WA-1:0] mem_wr_addr;
  logic [WB-1:0] mem_wr_data;

  // decision signals
  logic [XW-1:0] eff_x;
  logic [XW-1:0] sp_x;
  logic [XW-1:0] trk_x;
  logic [XW-1:0] in_page_x;
  logic [XW-1:0] lim2;
  logic [XW-1:0] lim_m1;
  logic [QW-1:0] last_word;
  logic          p1_ok;
  logic          p2_ok;
  logic [WB-1:0] lo_mask;
  logic [WB-1:0] hi_mask;
  logic [WB-1:0] cand;
  logic          hit_any;
  logic [BW-1:0] hit_bit;
  logic [XW-1:0] hit_idx;
  logic          issue;
  logic          finish;
  logic [1:0]    status_next;
  logic [11:0]   granted_next;
  logic [11:0]   search_position_next;
  logic [12:0]   used_next;
  logic [12:0]   reserved_next;
  logic [13:0]   taken;
  logic [FW-1:0] free_full;
  logic [12:0]   free_next;
  logic          is_set;
  logic          want_set;
  logic [WB-1:0] bit_mask;
  logic          cfg_wr;

  function automatic logic [BW-1:0] first_set(input logic [WB-1:0] v);
    logic [BW-1:0] idx;
    idx = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BW'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [12:0] cnt_inc(input logic [12:0] c);
    return (c == pba_pkg::CNT_MAX) ? c : c + 13'd1;
  endfunction

  function automatic logic [12:0] cnt_dec(input logic [12:0] c);
    return (c == 13'd0) ? c : c - 13'd1;
  endfunction

  pba_map #(
    .NW (NW),
    .WA (WA)
  ) u_map (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // Configuration port: always ready, one register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == pba_pkg::REG_TRACKED_PAGES);
  assign prdata = (paddr[2] == pba_pkg::REG_TRACKED_PAGES) ?
                  {19'd0, tracked_pages} : 32'd0;

  assign busy = (state != S_IDLE);

  // Effective tracked count: clamp to the map size
  assign trk_x     = XW'(tracked_pages);
  assign eff_x     = (trk_x > MAX_X) ? MAX_X : trk_x;
  assign sp_x      = XW'(search_position);
  assign in_page_x = XW'(page);
  assign p1_ok     = (sp_x < eff_x);
  assign lim2      = p1_ok ? sp_x : eff_x;
  assign p2_ok     = (lim2 != '0);
  assign lim_m1    = lim - XW'(1);
  assign last_word = lim_m1[XW-1:BW];

  // Window of candidate pages within the word being checked: [base, lim)
  always_comb begin
    if (chk_word > base[XW-1:BW]) begin
      lo_mask = ONES;
    end else if (chk_word == base[XW-1:BW]) begin
      lo_mask = ONES << base[BW-1:0];
    end else begin
      lo_mask = '0;
    end
    if (chk_word < lim[XW-1:BW]) begin
      hi_mask = ONES;
    end else if (chk_word == lim[XW-1:BW]) begin
      hi_mask = ~(ONES << lim[BW-1:0]);
    end else begin
      hi_mask = '0;
    end
  end

  assign cand     = ~mem_rd_data & lo_mask & hi_mask;
  assign hit_any  = |cand;
  assign hit_bit  = first_set(cand);
  assign hit_idx  = {chk_word, hit_bit};
  assign bit_mask = {{(WB-1){1'b0}}, 1'b1} << cur_page[BW-1:0];
  assign is_set   = mem_rd_data[cur_page[BW-1:0]];
  assign want_set = (cur_action == pba_pkg::ACT_LOCK) ||
                    (cur_action == pba_pkg::ACT_RESERVE);

  // Memory control, completion and counter updates
  always_comb begin
    finish               = 1'b0;
    status_next          = pba_pkg::ST_DONE;
    granted_next         = '0;
    search_position_next = search_position;
    used_next            = used_count;
    reserved_next        = reserved_count;
    mem_rd_en            = 1'b0;
    mem_rd_addr          = scan_word[WA-1:0];
    mem_wr_en            = 1'b0;
    mem_wr_addr          = chk_word[WA-1:0];
    mem_wr_data          = mem_rd_data | (ONES & ({{(WB-1){1'b0}}, 1'b1} << hit_bit));
    issue                = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_addr;
        mem_wr_data = '0;
      end
      S_IDLE: begin
        if (start) begin
          if (action == pba_pkg::ACT_REQUEST) begin
            if (!p1_ok && !p2_ok) begin
              finish      = 1'b1;
              status_next = pba_pkg::ST_NO_FREE;
            end
          end else if (action > pba_pkg::ACT_UNRESERVE) begin
            finish = 1'b1;
          end else if (in_page_x >= eff_x) begin
            finish      = 1'b1;
            status_next = pba_pkg::ST_RANGE;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = in_page_x[BW +: WA];
          end
        end
      end
      S_SCAN: begin
        issue       = (scan_word <= last_word) && !(chk_valid && hit_any);
        mem_rd_en   = issue;
        mem_rd_addr = scan_word[WA-1:0];
        if (chk_valid && hit_any) begin
          // claim the first clear page and move the position past it
          mem_wr_en            = 1'b1;
          finish               = 1'b1;
          granted_next         = hit_idx[11:0];
          search_position_next = hit_idx[11:0] + 12'd1;
          used_next            = cnt_inc(used_count);
        end else if (chk_valid && (chk_word == last_word)) begin
          if (!phase_one || !p2_ok) begin
            finish      = 1'b1;
            status_next = pba_pkg::ST_NO_FREE;
          end
        end
      end
      S_CHECK: begin
        finish      = 1'b1;
        mem_wr_addr = cur_page[BW +: WA];
        mem_wr_data = want_set ? (mem_rd_data | bit_mask) : (mem_rd_data & ~bit_mask);
        if (want_set == is_set) begin
          status_next = pba_pkg::ST_ALREADY;
        end else begin
          mem_wr_en = 1'b1;
          if (cur_action == pba_pkg::ACT_LOCK) begin
            used_next = cnt_inc(used_count);
          end else if (cur_action == pba_pkg::ACT_FREE) begin
            used_next = cnt_dec(used_count);
          end else if (cur_action == pba_pkg::ACT_RESERVE) begin
            reserved_next = cnt_inc(reserved_count);
          end else begin
            reserved_next = cnt_dec(reserved_count);
          end
        end
      end
      default: begin
        finish = 1'b0;
      end
    endcase

    // free = tracked - used - reserved, floor zero, ceiling at counter max
    taken     = {1'b0, used_next} + {1'b0, reserved_next};
    free_full = (FW'(eff_x) > FW'(taken)) ? FW'(eff_x) - FW'(taken) : '0;
    free_next = (free_full > FW'(pba_pkg::CNT_MAX)) ? pba_pkg::CNT_MAX : free_full[12:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_addr        <= '0;
      done            <= 1'b0;
      chk_valid       <= 1'b0;
      tracked_pages   <= pba_pkg::TRACKED_RESET;
      search_position <= '0;
      used_count      <= '0;
      reserved_count  <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_wr) begin
        tracked_pages <= pwdata[12:0];
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + WA'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cur_action <= action;
            cur_page   <= page;
            chk_valid  <= 1'b0;
            if (action == pba_pkg::ACT_REQUEST) begin
              // forward pass first, else straight to the wrap-around pass
              if (p1_ok) begin
                base      <= sp_x;
                lim       <= eff_x;
                phase_one <= 1'b1;
                scan_word <= sp_x[XW-1:BW];
              end else begin
                base      <= '0;
                lim       <= lim2;
                phase_one <= 1'b0;
                scan_word <= '0;
              end
              state <= S_SCAN;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_SCAN: begin
          chk_valid <= issue;
          chk_word  <= scan_word;
          if (issue) begin
            scan_word <= scan_word + QW'(1);
          end
          if (chk_valid && !hit_any && (chk_word == last_word) && phase_one && p2_ok) begin
            // forward pass exhausted: wrap to page zero
            base      <= '0;
            lim       <= lim2;
            phase_one <= 1'b0;
            scan_word <= '0;
            chk_valid <= 1'b0;
          end
        end
        S_CHECK: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (finish) begin
        state           <= S_IDLE;
        chk_valid       <= 1'b0;
        done            <= 1'b1;
        used_count      <= used_next;
        reserved_count  <= reserved_next;
        search_position <= search_position_next;
        granted_page    <= granted_next;
        status          <= status_next;
        used_pages      <= used_next;
        reserved_pages  <= reserved_next;
        free_pages      <= free_next;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_no_write_idle : assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_wr_en)
    else $error("busy map written while idle");

  a_free_bound : assert property (@(posedge clk) disable iff (rst)
    done |-> (XW'(free_pages) <= eff_x))
    else $error("free count above tracked count");

  a_next_fit : assert property (@(posedge clk) disable iff (rst)
    (done && (cur_action == pba_pkg::ACT_REQUEST) && (status == pba_pkg::ST_DONE))
      |-> (search_position == granted_page + 12'd1))
    else $error("search position not moved past granted page");
`endif

endmodule

/* tb/page_bitmap_allocator_unit_tb.sv */
// ============================================================================
// page_bitmap_allocator_unit_tb - self-checking bench for the page allocator
// A directed table of requests covers the edge cases. Phases of random requests
// follow, each under its own tracked_pages setting. Every result is compared
// field by field with its table row or a cycle-free predictor of map and counters.
// ============================================================================
module page_bitmap_allocator_unit_tb;

  localparam int          MAP_PAGES    = 4096;
  localparam int          SETTLE_WAIT  = 72;        // worst request latency plus margin
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int          PHASES       = 14;
  localparam int          PHASE_ITEMS  = 100;
  localparam int          RANDOM_ITEMS = PHASES * PHASE_ITEMS;

  // action codes the block does not know: reported as done, nothing changes
  localparam logic [2:0] ACT_BAD5 = 3'd5;
  localparam logic [2:0] ACT_BAD6 = 3'd6;
  localparam logic [2:0] ACT_BAD7 = 3'd7;

  typedef struct packed {
    logic [11:0]       granted;
    pba_pkg::status_t  status;
    logic [12:0]       used;
    logic [12:0]       reserved;
    logic [12:0]       free_cnt;
  } alloc_result_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    logic [2:0]    act;
    logic [11:0]   pg;
    logic [12:0]   cfg_val;
    alloc_result_t res;
  } stim_row_t;

  // DUT signals
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  action = '0;
  logic [11:0] page = '0;
  logic        done;
  logic [11:0] granted_page;
  logic [1:0]  status;
  logic [12:0] used_pages;
  logic [12:0] reserved_pages;
  logic [12:0] free_pages;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state: busy map, next-fit position, counters, configuration
  bit          page_taken [MAP_PAGES];
  logic [11:0] next_fit_pos;
  logic [12:0] used_q;
  logic [12:0] reserved_q;
  logic [12:0] tracked_q;

  alloc_result_t pending_results[$];
  stim_row_t     dir_rows[$];
  int unsigned   errors = 0;
  int unsigned   cycle_count = 0;

  page_bitmap_allocator_unit uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [12:0] sat_inc(logic [12:0] c);
    return (c >= pba_pkg::CNT_MAX) ? pba_pkg::CNT_MAX : c + 13'd1;
  endfunction

  function automatic logic [12:0] sat_dec(logic [12:0] c);
    return (c == 13'd0) ? 13'd0 : c - 13'd1;
  endfunction

  // Tracked count as the block sees it: anything above the map size is clipped
  function automatic int unsigned tracked_limit();
    return (tracked_q > MAP_PAGES) ? 32'(MAP_PAGES) : 32'(tracked_q);
  endfunction

  // Apply one request to the predictor state and return what the block reports
  function automatic alloc_result_t apply_action(logic [2:0] act, logic [11:0] pg);
    alloc_result_t r;
    int unsigned   lim, from, wrap_end, hit, taken;
    bit            found, want_set;
    lim   = tracked_limit();
    r     = '0;
    found = 1'b0;
    hit   = 0;
    if (act == pba_pkg::ACT_REQUEST) begin
      // next fit: search position up to the end, then wrap round from page zero
      from     = 32'(next_fit_pos);
      wrap_end = (from < lim) ? from : lim;
      for (int unsigned i = from; i < lim && !found; i++)
        if (!page_taken[i]) begin
          hit   = i;
          found = 1'b1;
        end
      for (int unsigned i = 0; i < wrap_end && !found; i++)
        if (!page_taken[i]) begin
          hit   = i;
          found = 1'b1;
        end
      if (found) begin
        page_taken[hit] = 1'b1;
        used_q          = sat_inc(used_q);
        next_fit_pos    = 12'(hit + 1);
        r.granted       = 12'(hit);
      end else begin
        r.status = pba_pkg::ST_NO_FREE;
      end
    end else if (act <= pba_pkg::ACT_UNRESERVE) begin
      want_set = (act == pba_pkg::ACT_LOCK) || (act == pba_pkg::ACT_RESERVE);
      if (pg >= lim) begin
        r.status = pba_pkg::ST_RANGE;
      end else if (page_taken[pg] == want_set) begin
        r.status = pba_pkg::ST_ALREADY;
      end else begin
        // the map keeps no owner, so the action alone picks the counter
        page_taken[pg] = want_set;
        case (act)
          pba_pkg::ACT_LOCK:    used_q     = sat_inc(used_q);
          pba_pkg::ACT_FREE:    used_q     = sat_dec(used_q);
          pba_pkg::ACT_RESERVE: reserved_q = sat_inc(reserved_q);
          default:              reserved_q = sat_dec(reserved_q);
        endcase
      end
    end
    taken      = 32'(used_q) + 32'(reserved_q);
    r.used     = used_q;
    r.reserved = reserved_q;
    r.free_cnt = (lim > taken) ? 13'(lim - taken) : 13'd0;
    return r;
  endfunction

  function automatic void check_field(string name, logic [12:0] want, logic [12:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Compare every strobed result with the oldest outstanding expectation
  always @(posedge clk) begin : result_check
    alloc_result_t exp_res;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing outstanding: expected none, got page %0d status %0d",
                 $time, granted_page, status);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("granted_page", 13'(exp_res.granted), 13'(granted_page));
        check_field("status", 13'(exp_res.status), 13'(status));
        check_field("used_pages", exp_res.used, used_pages);
        check_field("reserved_pages", exp_res.reserved, reserved_pages);
        check_field("free_pages", exp_res.free_cnt, free_pages);
      end
    end
  end

  // Table builders
  function automatic void row_item(logic [2:0] a, logic [11:0] p);
    stim_row_t row;
    row = '{kind: ROW_ITEM, act: a, pg: p, cfg_val: '0, res: '0};
    dir_rows.push_back(row);
  endfunction

  function automatic void row_typed(logic [2:0] a, logic [11:0] p, logic [11:0] g,
                                    pba_pkg::status_t s, logic [12:0] u, logic [12:0] rs,
                                    logic [12:0] f);
    stim_row_t row;
    row = '{kind: ROW_TYPED, act: a, pg: p, cfg_val: '0, res: '{g, s, u, rs, f}};
    dir_rows.push_back(row);
  endfunction

  function automatic void row_cfg(logic [12:0] v);
    stim_row_t row;
    row = '{kind: ROW_CFG, act: '0, pg: '0, cfg_val: v, res: '0};
    dir_rows.push_back(row);
  endfunction

  // Present one request after an optional gap and hold it until accepted.
  // start is left high on return so a back-to-back request needs no drop.
  task automatic send_request(logic [2:0] act, logic [11:0] pg, int unsigned gap,
                              bit typed, alloc_result_t typed_res);
    alloc_result_t r;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    action <= act;
    page   <= pg;
    do @(posedge clk); while (busy !== 1'b0);
    r = apply_action(act, pg);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // Drop start, wait for every outstanding result and let the block go quiet
  task automatic settle();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // APB write of tracked_pages followed by a read-back
  task automatic write_tracked(logic [12:0] val);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {pba_pkg::REG_TRACKED_PAGES, 2'b00};
    pwdata  <= {19'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    tracked_q = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("tracked_pages read-back", val, rd[12:0]);
  endtask

  initial begin : stimulus
    int unsigned lim, roll, gap, idle_pct, n_sent;
    logic [2:0]  act;
    logic [11:0] pg;
    logic [12:0] tv;

    for (int i = 0; i < MAP_PAGES; i++) page_taken[i] = 1'b0;
    next_fit_pos = '0;
    used_q       = '0;
    reserved_q   = '0;
    tracked_q    = pba_pkg::TRACKED_RESET;
    n_sent       = 0;

    // Directed table, default tracked count first
    row_typed(pba_pkg::ACT_REQUEST, 12'd0, 12'd0, pba_pkg::ST_DONE,
              13'd1, 13'd0, 13'd4095);
    row_typed(pba_pkg::ACT_REQUEST, 12'd4095, 12'd1, pba_pkg::ST_DONE,
              13'd2, 13'd0, 13'd4094);
    row_typed(pba_pkg::ACT_LOCK, 12'd4095, 12'd0, pba_pkg::ST_DONE,
              13'd3, 13'd0, 13'd4093);
    row_typed(pba_pkg::ACT_LOCK, 12'd4095, 12'd0, pba_pkg::ST_ALREADY,
              13'd3, 13'd0, 13'd4093);
    row_typed(pba_pkg::ACT_FREE, 12'd0, 12'd0, pba_pkg::ST_DONE,
              13'd2, 13'd0, 13'd4094);
    row_typed(pba_pkg::ACT_FREE, 12'd0, 12'd0, pba_pkg::ST_ALREADY,
              13'd2, 13'd0, 13'd4094);
    row_typed(pba_pkg::ACT_RESERVE, 12'd2048, 12'd0, pba_pkg::ST_DONE,
              13'd2, 13'd1, 13'd4093);
    row_typed(pba_pkg::ACT_RESERVE, 12'd2048, 12'd0, pba_pkg::ST_ALREADY,
              13'd2, 13'd1, 13'd4093);
    row_typed(pba_pkg::ACT_UNRESERVE, 12'd2048, 12'd0, pba_pkg::ST_DONE,
              13'd2, 13'd0, 13'd4094);
    row_typed(pba_pkg::ACT_UNRESERVE, 12'd2048, 12'd0, pba_pkg::ST_ALREADY,
              13'd2, 13'd0, 13'd4094);
    row_typed(ACT_BAD5, 12'd0, 12'd0, pba_pkg::ST_DONE,
              13'd2, 13'd0, 13'd4094);
    row_typed(ACT_BAD6, 12'd4095, 12'd0, pba_pkg::ST_DONE,
              13'd2, 13'd0, 13'd4094);
    row_typed(ACT_BAD7, 12'hAAA, 12'd0, pba_pkg::ST_DONE,
              13'd2, 13'd0, 13'd4094);
    row_item(pba_pkg::ACT_REQUEST,   12'd0);
    // shared map: free a reserved page, unreserve a locked one
    row_item(pba_pkg::ACT_RESERVE,   12'd100);
    row_item(pba_pkg::ACT_FREE,      12'd100);
    row_item(pba_pkg::ACT_LOCK,      12'd200);
    row_item(pba_pkg::ACT_UNRESERVE, 12'd200);
    // oversized tracked count is clipped to the map size
    row_cfg(13'h1FFF);
    row_item(pba_pkg::ACT_REQUEST,   12'd0);
    // one page: range check, a wrapped search that takes page 0, then one that fails
    row_cfg(13'd1);
    row_item(pba_pkg::ACT_LOCK,      12'd1);
    row_item(pba_pkg::ACT_REQUEST,   12'd0);
    row_item(pba_pkg::ACT_REQUEST,   12'd0);
    // nothing tracked: every page out of range, every search fails
    row_cfg(13'd0);
    row_item(pba_pkg::ACT_REQUEST,   12'd0);
    row_item(pba_pkg::ACT_LOCK,      12'd0);
    row_item(pba_pkg::ACT_UNRESERVE, 12'd4095);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        write_tracked(dir_rows[i].cfg_val);
      end else begin
        send_request(dir_rows[i].act, dir_rows[i].pg, 0,
                     dir_rows[i].kind == ROW_TYPED, dir_rows[i].res);
      end
    end

    // Random phases, each under its own tracked count
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       tv = 13'd1;
        1:       tv = pba_pkg::TRACKED_RESET;
        2:       tv = 13'h1FFF;
        3:       tv = 13'd0;
        4:       tv = 13'd64;
        5:       tv = 13'd65;
        6:       tv = 13'($urandom_range(0, 8191));
        default: tv = 13'($urandom_range(2, 100));
      endcase
      settle();
      write_tracked(tv);
      lim = tracked_limit();

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // hold off now and then until the block has answered everything
        if (k == PHASE_ITEMS / 2 && ph % 4 == 1) settle();

        // requests dominate so small maps fill up and the search wraps
        roll = $urandom_range(0, 99);
        if (roll < 40)      act = pba_pkg::ACT_REQUEST;
        else if (roll < 55) act = pba_pkg::ACT_FREE;
        else if (roll < 70) act = pba_pkg::ACT_LOCK;
        else if (roll < 80) act = pba_pkg::ACT_RESERVE;
        else if (roll < 92) act = pba_pkg::ACT_UNRESERVE;
        else if (roll < 96) act = 3'($urandom_range(ACT_BAD5, ACT_BAD7));
        else                act = 3'($urandom_range(0, 7));

        case ($urandom_range(0, 9))
          0:       pg = 12'($urandom());
          1:       pg = 12'(lim + $urandom_range(0, 3));
          default: pg = (lim == 0) ? 12'($urandom_range(0, 3)) : 12'($urandom_range(0, lim - 1));
        endcase

        // sender idling per cycle: light, then heavy, then none
        if (n_sent < RANDOM_ITEMS / 3)          idle_pct = 15;
        else if (n_sent < 2 * RANDOM_ITEMS / 3) idle_pct = 61;
        else                                    idle_pct = 0;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct) gap++;

        send_request(act, pg, gap, 1'b0, '0);
        n_sent++;
      end
    end

    settle();
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
